>>> hdl/kpi_pkg.sv
// Shared types and constants for the keyframe pose interpolator.
`timescale 1ns / 1ps
package kpi_pkg;

  localparam int DEF_MAX_GAP    = 63;
  localparam int DEF_FRAME_BITS = 16;
  localparam int FRM_W          = 16;
  localparam int DIV_STEPS      = 33;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NOT_RISING = 2'd1;
  localparam logic [1:0] ERR_GAP        = 2'd2;

  typedef struct packed {
    logic [1:0]        err;
    logic              first;
    logic [FRM_W-1:0]  frame;
    logic [FRM_W-1:0]  base;
    logic [FRM_W-1:0]  gap;
    logic [5:0][31:0]  a;
    logic [5:0][31:0]  b;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERR,
    BK_DIV,
    BK_RUN
  } bk_state_t;

endpackage

>>> hdl/kpi_front.sv
// Front end: accept keyframes, keep the previous key, issue commands.
`timescale 1ns / 1ps
module kpi_front #(
  parameter int MAX_GAP    = 63,
  parameter int FRAME_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [159:0]  s_tdata,
  input  logic [0:0]    s_tuser,
  output logic          push,
  output kpi_pkg::cmd_t push_cmd,
  input  logic          full
);
  import kpi_pkg::*;

  localparam int FW = (FRAME_BITS < FRM_W) ? FRAME_BITS : FRM_W;

  logic [1:0]       keys_seen;
  logic [FRM_W-1:0] prev_frame;
  logic [5:0][31:0] prev_pose;

  logic             acc;
  logic             begin_track;
  logic [FRM_W-1:0] frm;
  logic [FRM_W-1:0] gap;
  logic [5:0][31:0] pose;

  assign s_tready = !full;
  assign acc      = s_tvalid && s_tready;
  assign frm      = FRM_W'(s_tdata[FW-1:0]);
  assign gap      = frm - prev_frame;
  assign begin_track = s_tuser[0] || (keys_seen == 2'd0);

  always_comb begin
    pose[0] = s_tdata[47:16];
    pose[1] = s_tdata[79:48];
    pose[2] = s_tdata[111:80];
    pose[3] = {{16{s_tdata[127]}}, s_tdata[127:112]};
    pose[4] = {{16{s_tdata[143]}}, s_tdata[143:128]};
    pose[5] = {{16{s_tdata[159]}}, s_tdata[159:144]};
  end

  always_comb begin
    push_cmd.frame = frm;
    push_cmd.base  = prev_frame;
    push_cmd.gap   = gap;
    push_cmd.first = (keys_seen != 2'd1);
    push_cmd.a     = prev_pose;
    push_cmd.b     = pose;
    if (frm <= prev_frame) begin
      push_cmd.err = ERR_NOT_RISING;
    end else if (gap > FRM_W'(MAX_GAP)) begin
      push_cmd.err = ERR_GAP;
    end else begin
      push_cmd.err = ERR_NONE;
    end
  end

  assign push = acc && !begin_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_seen  <= 2'd0;
      prev_frame <= '0;
      prev_pose  <= '0;
    end else if (acc) begin
      if (begin_track) begin
        keys_seen  <= 2'd1;
        prev_frame <= frm;
        prev_pose  <= pose;
      end else if (push_cmd.err == ERR_NONE) begin
        keys_seen  <= 2'd2;
        prev_frame <= frm;
        prev_pose  <= pose;
      end
    end
  end

endmodule

>>> hdl/kpi_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module kpi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kpi_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output kpi_pkg::cmd_t head
);
  import kpi_pkg::*;

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hdl/kpi_back.sv
// Back end: per-lane step divide, then incremental interpolation per frame.
`timescale 1ns / 1ps
module kpi_back #(
  parameter int MAX_GAP = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  kpi_pkg::cmd_t q_head,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [159:0]  m_tdata,
  output logic          m_tlast,
  output logic [1:0]    m_tuser
);
  import kpi_pkg::*;

  localparam int GW = (MAX_GAP < 2) ? 1 : $clog2(MAX_GAP + 1);

  bk_state_t state, state_next;

  logic [GW-1:0]    gap_r;
  logic [GW-1:0]    idx;
  logic             first_r;
  logic [1:0]       err_r;
  logic [FRM_W-1:0] frame_r;
  logic [FRM_W-1:0] base_r;
  logic [5:0]       cnt;

  logic [31:0]      a_r    [6];
  logic             neg    [6];
  logic [32:0]      mag    [6];
  logic [32:0]      quo    [6];
  logic [GW-1:0]    rem    [6];
  logic [32:0]      acc_q  [6];
  logic [GW-1:0]    acc_r  [6];

  logic             can_load;
  logic             ld_err;
  logic             ld_run;
  logic             step;
  logic [5:0][31:0] val;

  assign can_load = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = (q_head.err != ERR_NONE) ? BK_ERR : BK_DIV;
      BK_ERR:  if (can_load) state_next = BK_IDLE;
      BK_DIV:  if (cnt == 6'(DIV_STEPS - 1)) state_next = BK_RUN;
      BK_RUN:  if (can_load && idx == gap_r) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop    = 1'b0;
    ld_err = 1'b0;
    ld_run = 1'b0;
    step   = 1'b0;
    case (state)
      BK_IDLE: pop = q_valid;
      BK_ERR:  ld_err = can_load;
      BK_RUN: begin
        step   = can_load;
        ld_run = can_load && !(first_r && idx == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      val[j] = 32'({a_r[j][31], a_r[j]} + (neg[j] ? -acc_q[j] : acc_q[j]));
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] d;
    logic [GW:0] rsh;
    logic [GW:0] rsum;
    logic        ge;
    if (pop) begin
      gap_r   <= q_head.gap[GW-1:0];
      first_r <= q_head.first;
      err_r   <= q_head.err;
      frame_r <= q_head.frame;
      base_r  <= q_head.base;
      cnt     <= '0;
      idx     <= '0;
      for (int j = 0; j < 6; j++) begin
        d        = {q_head.b[j][31], q_head.b[j]} - {q_head.a[j][31], q_head.a[j]};
        a_r[j]   <= q_head.a[j];
        neg[j]   <= d[32];
        mag[j]   <= d[32] ? -d : d;
        quo[j]   <= '0;
        rem[j]   <= '0;
        acc_q[j] <= '0;
        acc_r[j] <= '0;
      end
    end else if (state == BK_DIV) begin
      cnt <= cnt + 6'd1;
      for (int j = 0; j < 6; j++) begin
        rsh    = {rem[j], mag[j][32]};
        ge     = (rsh >= {1'b0, gap_r});
        rem[j] <= ge ? GW'(rsh - {1'b0, gap_r}) : GW'(rsh);
        mag[j] <= {mag[j][31:0], 1'b0};
        quo[j] <= {quo[j][31:0], ge};
      end
    end else if (step) begin
      idx <= idx + GW'(1);
      for (int j = 0; j < 6; j++) begin
        rsum     = {1'b0, acc_r[j]} + {1'b0, rem[j]};
        ge       = (rsum >= {1'b0, gap_r});
        acc_r[j] <= ge ? GW'(rsum - {1'b0, gap_r}) : GW'(rsum);
        acc_q[j] <= acc_q[j] + quo[j] + 33'(ge);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_err) begin
      m_tdata <= {144'd0, frame_r};
      m_tlast <= 1'b1;
      m_tuser <= err_r;
    end else if (ld_run) begin
      m_tdata <= {val[5][15:0], val[4][15:0], val[3][15:0], val[2], val[1], val[0],
                  FRM_W'(base_r + FRM_W'(idx))};
      m_tlast <= (idx == gap_r);
      m_tuser <= ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                   m_tvalid <= 1'b0;
    else if (ld_err || ld_run) m_tvalid <= 1'b1;
    else if (m_tready)         m_tvalid <= 1'b0;
  end

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (gap_r != '0)) else $error("run with zero gap");
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ERR_NONE) |-> m_tlast) else $error("error result not last");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (acc_r[0] < gap_r && rem[0] < gap_r)) else $error("remainder overflow");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (idx <= gap_r)) else $error("frame index past gap");

endmodule

>>> hdl/keyframe_pose_interpolator_top.sv
// Top level of the linear keyframe pose interpolator.
`timescale 1ns / 1ps
// Usage:
//   Keyframes enter on the s_ channel in rising frame order. s_tuser[0] marks
//   the first keyframe of a new track; such an item is stored and yields no
//   result. Each later keyframe yields one interpolated pose per frame across
//   the gap (the second key of a track includes the previous frame as well).
//   Results leave on the m_ channel; m_tlast flags the final result of a key
//   and m_tuser carries the error code (not rising, gap too large), in which
//   case a single zero-pose result is sent and the keyframe is dropped.
//   Timing: the front takes one item per cycle, while the two-entry command
//   queue is not full. The back takes one command at a time: it loads the
//   command, runs the per-lane restoring divide of the pose delta by the gap,
//   then sends one result per cycle while m_tready does not stall it (gap or
//   gap+1 results). An error item is loaded and sends its single result.
//   Reset clears the stored key, the queue, the back sequencer and m_tvalid.
//   A stall on m_tready holds the result register and the back sequencer while it sends; the
//   front keeps accepting until the queue fills, then drops s_tready.
module keyframe_pose_interpolator_top #(
  parameter int MAX_GAP    = kpi_pkg::DEF_MAX_GAP,
  parameter int FRAME_BITS = kpi_pkg::DEF_FRAME_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame[15:0], pos_x, pos_y, pos_z, ang_theta, ang_phi, ang_psi
  input  logic [159:0] s_tdata,
  // start_track
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_frame[15:0], out_x, out_y, out_z, out_theta, out_phi, out_psi
  output logic [159:0] m_tdata,
  output logic         m_tlast,
  // error
  output logic [1:0]   m_tuser
);
  import kpi_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_head;

  // accept and classify keyframes
  kpi_front #(.MAX_GAP(MAX_GAP), .FRAME_BITS(FRAME_BITS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .push(push), .push_cmd(push_cmd), .full(full)
  );

  // decouple the two halves
  kpi_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .valid(q_valid), .head(q_head)
  );

  // divide and emit poses
  kpi_back #(.MAX_GAP(MAX_GAP)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule

>>> tb/keyframe_pose_interpolator_top_tb.sv
// Self-checking testbench for the keyframe pose interpolator top level.
`timescale 1ns / 1ps
module keyframe_pose_interpolator_top_tb;
  import kpi_pkg::*;

  localparam int MAXGAP = DEF_MAX_GAP;
  localparam int WDOG_LIMIT = 200000;
  localparam int HOLD_OFF_LEN = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic         m_tlast;
  logic [1:0]   m_tuser;

  // One pose result as it leaves the block.
  typedef struct packed {
    logic [1:0]   err;
    logic         last;
    logic [159:0] data;
  } pose_res_t;

  pose_res_t pending_poses[$];

  // Own copy of the interpolator state.
  int unsigned   track_keys;
  logic [15:0]   key_frame;
  logic [2:0][31:0] key_pos;
  logic [2:0][15:0] key_ang;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off_flag = 1'b0;
  bit  hold_off_seen = 1'b0;
  int  hold_off_left = 0;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  keyframe_pose_interpolator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // start + (end-start)*i/gap, truncated toward zero (SV signed / truncates).
  function automatic logic [31:0] blend(longint a, longint b, longint i, longint gap);
    longint v;
    v = a + ((b - a) * i) / gap;
    return v[31:0];
  endfunction

  function automatic pose_res_t zero_pose(logic [15:0] frm, logic [1:0] err);
    pose_res_t r;
    r.err  = err;
    r.last = 1'b1;
    r.data = {144'd0, frm};
    return r;
  endfunction

  // Append one expected result at the tail of the queue.
  function automatic void expect_pose(pose_res_t r);
    pending_poses = {pending_poses, r};
  endfunction

  // Work out the results of one accepted keyframe and queue them.
  task automatic predict_keyframe(input logic start, input logic [159:0] d);
    logic [15:0] frm;
    longint gap;
    longint i;
    pose_res_t r;
    logic [2:0][31:0] npos;
    logic [2:0][15:0] nang;
    frm = d[15:0];
    for (int j = 0; j < 3; j++) begin
      npos[j] = d[16 + 32*j +: 32];
      nang[j] = d[112 + 16*j +: 16];
    end
    if (start || track_keys == 0) begin
      key_frame = frm; key_pos = npos; key_ang = nang; track_keys = 1;
      return;
    end
    if (frm <= key_frame) begin
      expect_pose(zero_pose(frm, ERR_NOT_RISING));
      return;
    end
    gap = longint'(frm) - longint'(key_frame);
    if (gap > MAXGAP) begin
      expect_pose(zero_pose(frm, ERR_GAP));
      return;
    end
    for (i = (track_keys == 1) ? 0 : 1; i <= gap; i++) begin
      r.err = ERR_NONE;
      r.last = (i == gap);
      r.data[15:0] = key_frame + 16'(i);
      for (int j = 0; j < 3; j++) begin
        r.data[16 + 32*j +: 32] = blend(longint'($signed(key_pos[j])),
                                        longint'($signed(npos[j])), i, gap);
        r.data[112 + 16*j +: 16] = 16'(blend(longint'($signed(key_ang[j])),
                                             longint'($signed(nang[j])), i, gap));
      end
      expect_pose(r);
    end
    key_frame = frm; key_pos = npos; key_ang = nang; track_keys = 2;
  endtask

  // Offer one keyframe, idling first at the current rate; hold until taken.
  // Valid stays high after the handshake so items can follow back to back.
  task automatic send_keyframe(input logic start, input logic [15:0] frm,
                               input logic [2:0][31:0] pos, input logic [2:0][15:0] ang);
    logic [159:0] d;
    d = {ang[2], ang[1], ang[0], pos[2], pos[1], pos[0], frm};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    predict_keyframe(start, d);
  endtask

  function automatic logic [31:0] rand_pos(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Random-content key at a given frame.
  task automatic send_rand_key(input logic start, input logic [15:0] frm);
    logic [2:0][31:0] pos;
    logic [2:0][15:0] ang;
    for (int j = 0; j < 3; j++) begin
      pos[j] = rand_pos($urandom_range(5));
      ang[j] = 16'(rand_pos($urandom_range(5)));
    end
    send_keyframe(start, frm, pos, ang);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    // error items produce nothing more; allow the back end to settle
    repeat (80) @(posedge clk);
  endtask

  // Extremes of every field, both error kinds, second and later keys.
  task automatic test_directed();
    logic [2:0][31:0] lo_p, hi_p;
    logic [2:0][15:0] lo_a, hi_a;
    lo_p = {3{32'h8000_0000}}; hi_p = {3{32'h7FFF_FFFF}};
    lo_a = {3{16'h8000}};      hi_a = {3{16'h7FFF}};
    // first key without start_track, after reset
    send_keyframe(1'b0, 16'd0, lo_p, lo_a);
    send_keyframe(1'b0, 16'd63, hi_p, hi_a);        // second key, largest gap
    send_keyframe(1'b0, 16'd64, lo_p, lo_a);        // later key, gap 1
    send_keyframe(1'b0, 16'd64, hi_p, hi_a);        // equal frame: not rising
    send_keyframe(1'b0, 16'd10, hi_p, hi_a);        // backwards
    send_keyframe(1'b0, 16'd128, hi_p, hi_a);       // gap 64: too large
    send_keyframe(1'b0, 16'd127, hi_p, lo_a);       // gap 63 later key
    send_keyframe(1'b1, 16'hFFC0, hi_p, hi_a);      // new track near the top
    send_keyframe(1'b0, 16'hFFFF, lo_p, lo_a);
    send_keyframe(1'b0, 16'hFFFF, lo_p, lo_a);      // not rising at the top
    send_keyframe(1'b1, 16'd5, {3{32'h0000_0007}}, {3{16'hFFF9}});
    send_keyframe(1'b0, 16'd8, {3{32'hFFFF_FFF9}}, {3{16'h0007}}); // rounding to zero
    send_keyframe(1'b1, 16'd100, {3{32'h5555_AAAA}}, {3{16'h5A5A}});
    send_keyframe(1'b1, 16'd200, {3{32'hAAAA_5555}}, {3{16'hA5A5}}); // restart, no result
    send_keyframe(1'b0, 16'd201, {3{32'h5555_AAAA}}, {3{16'h5A5A}});
    wait_drained();
  endtask

  // Mostly well-formed tracks with small gaps, some broken keys.
  task automatic test_random(input int n_keys);
    logic [15:0] frm;
    int kind;
    frm = 16'($urandom);
    for (int k = 0; k < n_keys; k++) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        frm = 16'($urandom);
        send_rand_key(1'b1, frm);
      end else if (kind < 14) begin
        send_rand_key(1'b0, frm - 16'($urandom_range(300)));
      end else if (kind < 19) begin
        send_rand_key(1'b0, frm + 16'($urandom_range(MAXGAP + 1, 2000)));
      end else begin
        if (frm > 16'hFFFF - MAXGAP) begin
          frm = 16'($urandom_range(1000));
          send_rand_key(1'b1, frm);
        end else begin
          frm = frm + 16'(($urandom_range(9) == 0) ? $urandom_range(1, MAXGAP)
                                                    : $urandom_range(1, 6));
          send_rand_key(1'b0, frm);
        end
      end
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while keys keep coming.
  task automatic test_backpressure();
    hold_off_flag = !hold_off_flag;
    send_rand_key(1'b1, 16'd1000);
    for (int k = 1; k <= 6; k++) send_rand_key(1'b0, 16'(1000 + 20*k));
    wait_drained();
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_flag != hold_off_seen) begin
      hold_off_seen <= hold_off_flag;
      hold_off_left <= HOLD_OFF_LEN - 1;
      m_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pose_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result data=%h last=%b err=%0d",
                 $time, m_tdata, m_tlast, m_tuser);
        failed = 1'b1;
      end else begin
        want = pending_poses.pop_front();
        if (want.data !== m_tdata) begin
          $display("%0t: data expected %h actual %h", $time, want.data, m_tdata);
          failed = 1'b1;
        end
        if (want.last !== m_tlast) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          failed = 1'b1;
        end
        if (want.err !== m_tuser) begin
          $display("%0t: error expected %0d actual %0d", $time, want.err, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run after too long with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("keyframe_pose_interpolator_top test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(90);
    send_idle_pct = 87; recv_stall_pct = 0;  test_random(80);
    send_idle_pct = 0;  recv_stall_pct = 87; test_random(80);
    send_idle_pct = 10; recv_stall_pct = 10; test_random(80);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();
    if (pending_poses.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("keyframe_pose_interpolator_top test passed");
    end else begin
      $display("keyframe_pose_interpolator_top test failed");
    end
    $finish;
  end

endmodule
